/* hw/rtl/jse_pkg.sv */
// shared types, character codes and helpers for the json string escaper
package jse_pkg;

  localparam int unsigned MaxResults = 10;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned PreDepth   = 4;
  localparam int unsigned BodyDepth  = 6;

  typedef enum logic [1:0] {
    ActData  = 2'd0,
    ActEmpty = 2'd1,
    ActNull  = 2'd2,
    ActNone  = 2'd3
  } action_e;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChUnder = 8'h5F;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChLowerB = 8'h62;
  localparam logic [7:0] ChLowerF = 8'h66;
  localparam logic [7:0] ChLowerL = 8'h6C;
  localparam logic [7:0] ChLowerN = 8'h6E;
  localparam logic [7:0] ChLowerR = 8'h72;
  localparam logic [7:0] ChLowerT = 8'h74;
  localparam logic [7:0] ChLowerU = 8'h75;

  // one word's worth of output text, in segments
  typedef struct packed {
    logic                      open;
    logic [PreDepth-1:0][7:0]  pre;
    logic [2:0]                pre_len;
    logic [BodyDepth-1:0][7:0] body;
    logic [2:0]                body_len;
    logic [1:0]                tail_len;
    logic                      close;
  } rec_t;

  function automatic logic [3:0] rec_total(rec_t r);
    return {3'b0, r.open} + {1'b0, r.pre_len} + {1'b0, r.body_len}
         + {2'b0, r.tail_len} + {3'b0, r.close};
  endfunction

  function automatic logic [7:0] hex_digit(logic [3:0] v);
    return (v < 4'd10) ? (ChZero + {4'b0, v}) : (ChUpperA + {4'b0, v} - 8'd10);
  endfunction

endpackage

/* hw/rtl/jse_front.sv */
// front end: utf-8 tracking and classification of each input word into a text record
module jse_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          space_i,
  input  logic [1:0]    action_i,
  input  logic [7:0]    data_byte_i,
  input  logic          first_byte_i,
  input  logic          last_byte_i,
  output logic          in_ready_o,
  output logic          push_o,
  output jse_pkg::rec_t rec_o
);
  import jse_pkg::*;

  localparam logic [7:0] LeadE0 = 8'hE0;
  localparam logic [7:0] LeadED = 8'hED;
  localparam logic [7:0] LeadF0 = 8'hF0;
  localparam logic [7:0] LeadF4 = 8'hF4;

  logic [2:0][7:0] held_q, held_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [2:0]      seq_q, seq_d;
  rec_t            rec;
  logic            accept;

  always_comb begin
    logic [1:0] h;
    logic [7:0] b;
    logic [7:0] lo;
    logic [7:0] hi;
    logic       fresh;
    rec    = '0;
    held_d = held_q;
    cnt_d  = cnt_q;
    seq_d  = seq_q;
    b      = data_byte_i;
    h      = 2'd0;
    lo     = 8'h80;
    hi     = 8'hBF;
    fresh  = 1'b0;
    case (action_e'(action_i))
      ActEmpty: begin
        rec.body[0]  = ChQuote;
        rec.body[1]  = ChQuote;
        rec.body_len = 3'd2;
        cnt_d = 2'd0;
        seq_d = 3'd0;
      end
      ActNull: begin
        rec.body[0]  = ChLowerN;
        rec.body[1]  = ChLowerU;
        rec.body[2]  = ChLowerL;
        rec.body[3]  = ChLowerL;
        rec.body_len = 3'd4;
        cnt_d = 2'd0;
        seq_d = 3'd0;
      end
      ActData: begin
        rec.open = first_byte_i;
        h = first_byte_i ? 2'd0 : cnt_q;
        if (h == 2'd0) begin
          fresh = 1'b1;
          cnt_d = 2'd0;
          seq_d = 3'd0;
        end else begin
          if (h == 2'd1) begin
            case (held_q[0])
              LeadE0: lo = 8'hA0;
              LeadED: hi = 8'h9F;
              LeadF0: lo = 8'h90;
              LeadF4: hi = 8'h8F;
              default: ;
            endcase
          end
          if (b >= lo && b <= hi) begin
            if ({1'b0, h} + 3'd1 >= seq_q) begin
              // sequence complete: copy held bytes and this one
              for (int i = 0; i < 3; i++) begin
                if (i < int'(h)) rec.pre[i] = held_q[i];
              end
              rec.pre[h] = b;
              rec.pre_len = {1'b0, h} + 3'd1;
              cnt_d = 2'd0;
              seq_d = 3'd0;
            end else begin
              held_d[h] = b;
              cnt_d = h + 2'd1;
            end
          end else begin
            // broken sequence: one underscore per held byte, byte starts over
            for (int i = 0; i < PreDepth; i++) rec.pre[i] = ChUnder;
            rec.pre_len = {1'b0, h};
            cnt_d = 2'd0;
            seq_d = 3'd0;
            fresh = 1'b1;
          end
        end
        if (fresh) begin
          if (b < 8'h20) begin
            rec.body[0] = ChBslash;
            rec.body_len = 3'd2;
            case (b)
              8'h08: rec.body[1] = ChLowerB;
              8'h0C: rec.body[1] = ChLowerF;
              8'h0A: rec.body[1] = ChLowerN;
              8'h0D: rec.body[1] = ChLowerR;
              8'h09: rec.body[1] = ChLowerT;
              default: begin
                rec.body[1] = ChLowerU;
                rec.body[2] = ChZero;
                rec.body[3] = ChZero;
                rec.body[4] = hex_digit(b[7:4]);
                rec.body[5] = hex_digit(b[3:0]);
                rec.body_len = 3'd6;
              end
            endcase
          end else if (b < 8'h80) begin
            if (b == ChBslash || b == ChQuote) begin
              rec.body[0] = ChBslash;
              rec.body[1] = b;
              rec.body_len = 3'd2;
            end else begin
              rec.body[0] = b;
              rec.body_len = 3'd1;
            end
          end else if (b inside {[8'hC2:8'hF4]}) begin
            held_d[0] = b;
            cnt_d = 2'd1;
            seq_d = (b < 8'hE0) ? 3'd2 : ((b < 8'hF0) ? 3'd3 : 3'd4);
          end else begin
            rec.body[0] = ChUnder;
            rec.body_len = 3'd1;
          end
        end
        if (last_byte_i) begin
          // truncated tail: underscores for what is still held
          rec.tail_len = cnt_d;
          rec.close = 1'b1;
          cnt_d = 2'd0;
          seq_d = 3'd0;
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o = space_i;
  assign accept     = in_valid_i && space_i;
  assign push_o     = accept && (rec_total(rec) != 4'd0);
  assign rec_o      = rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      seq_q <= 3'd0;
    end else if (accept) begin
      cnt_q <= cnt_d;
      seq_q <= seq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) held_q <= held_d;
  end

endmodule

/* hw/rtl/jse_fifo.sv */
// short record queue between front and back
module jse_fifo #(
  parameter int unsigned Depth = jse_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jse_pkg::rec_t wdata_i,
  input  logic          pop_i,
  output jse_pkg::rec_t rdata_o,
  output logic          full_o,
  output logic          empty_o
);
  import jse_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  rec_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
      if (pop_i)  rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

endmodule

/* hw/rtl/jse_back.sv */
// back end: walks the head record one character per word
module jse_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  jse_pkg::rec_t rec_i,
  input  logic          avail_i,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output logic [7:0]    out_char_o,
  output logic          run_end_o,
  output logic          pop_o
);
  import jse_pkg::*;

  logic [3:0] idx_q, idx_d;
  logic [3:0] total;
  logic       fire;

  always_comb begin
    logic [3:0] p1;
    logic [3:0] p2;
    logic [3:0] p3;
    p1 = idx_q - {3'b0, rec_i.open};
    p2 = p1 - {1'b0, rec_i.pre_len};
    p3 = p2 - {1'b0, rec_i.body_len};
    if (rec_i.open && idx_q == 4'd0) out_char_o = ChQuote;
    else if (p1 < {1'b0, rec_i.pre_len}) out_char_o = rec_i.pre[p1[1:0]];
    else if (p2 < {1'b0, rec_i.body_len}) out_char_o = rec_i.body[p2[2:0]];
    else if (p3 < {2'b0, rec_i.tail_len}) out_char_o = ChUnder;
    else out_char_o = ChQuote;
  end

  assign total       = rec_total(rec_i);
  assign out_valid_o = avail_i;
  assign run_end_o   = (idx_q == total - 4'd1);
  assign fire        = avail_i && out_ready_i;
  assign pop_o       = fire && run_end_o;
  assign idx_d       = pop_o ? 4'd0 : (fire ? idx_q + 4'd1 : idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= 4'd0;
    else idx_q <= idx_d;
  end

endmodule

/* hw/rtl/json_string_escaper_utf8_unit.sv */
// top level of the json string escaper with strict utf-8 checking
// an accepted word's record is queued; its text comes out once it heads the queue
// throughput: one input word per cycle while the record queue has room,
//   one output character per cycle while out_ready is high; a word of n characters
//   holds the back end until all are out, so escapes stall input once the queue fills
// reset: asynchronous, clears the held utf-8 bytes count, the queue and the char index
module json_string_escaper_utf8_unit #(
  parameter int unsigned QueueDepth = jse_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input words, one string byte each
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] action_i,
  input  logic [7:0] data_byte_i,
  input  logic       first_byte_i,
  input  logic       last_byte_i,
  // output words, one json text byte each
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       run_end_o
);
  import jse_pkg::*;

  rec_t front_rec, head_rec;
  logic push, pop, full, empty;

  // front: utf-8 state and classification, one word per cycle while the queue has room
  jse_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .space_i      (!full),
    .action_i     (action_i),
    .data_byte_i  (data_byte_i),
    .first_byte_i (first_byte_i),
    .last_byte_i  (last_byte_i),
    .in_ready_o   (in_ready_o),
    .push_o       (push),
    .rec_o        (front_rec)
  );

  // queue decouples classification from character output
  jse_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (front_rec),
    .pop_i   (pop),
    .rdata_o (head_rec),
    .full_o  (full),
    .empty_o (empty)
  );

  // back: serializes the head record
  jse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (head_rec),
    .avail_i     (!empty),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_char_o  (out_char_o),
    .run_end_o   (run_end_o),
    .pop_o       (pop)
  );

  // a record is never pushed into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !full)
    else $error("record pushed into full queue");

  // every pushed record carries between one and the maximum characters
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (rec_total(front_rec) != 4'd0 &&
              rec_total(front_rec) <= 4'(MaxResults)))
    else $error("record length out of range");

  // the unused action code never produces text
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && action_i == ActNone) |-> !push)
    else $error("unused action produced a record");

  // popping only on the final character of a record
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> (run_end_o && !empty))
    else $error("record popped before its last character");

endmodule

/* bench/tb_top.sv */
// self-checking testbench for the json string escaper with strict utf-8 checking
`timescale 1ns / 1ps

module tb_top;
  import jse_pkg::*;

  // run shape
  localparam int unsigned TargetWords  = 470;   // data, empty and null words
  localparam int unsigned CalmAfter    = 410;   // no idling from here on
  localparam int unsigned WatchdogMax  = 2000;  // cycles with no handshake at all
  localparam int unsigned DrainCycles  = 16;    // quiet tail after the last character
  localparam int unsigned ShownErrors  = 10;

  // one expected character of json text
  typedef struct packed {
    logic [7:0] ch;
    logic       tail;
  } text_byte_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_action = ActData;
  logic [7:0] in_byte = 8'h00;
  logic       in_first = 1'b0;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b1;
  logic [7:0] out_char;
  logic       out_run_end;

  json_string_escaper_utf8_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .action_i     (in_action),
    .data_byte_i  (in_byte),
    .first_byte_i (in_first),
    .last_byte_i  (in_last),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_char_o   (out_char),
    .run_end_o    (out_run_end)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // escaper model: utf-8 hold buffer and the text it produces
  // ---------------------------------------------------------------------------
  logic [7:0]  held_q [3];
  logic [1:0]  held_n = 2'd0;
  logic [2:0]  seq_n = 3'd0;
  logic [7:0]  word_chars[$];
  text_byte_t  escaped_text_q[$];
  string       hex_text = "0123456789ABCDEF";

  // idling odds, changed as the run goes on
  int unsigned send_pct = 20;
  int unsigned stall_pct = 5;
  logic [4:0]  stall_left = '0;

  int unsigned err_count = 0;
  int unsigned data_words = 0;
  int unsigned strings_sent = 0;
  int unsigned chars_checked = 0;
  int unsigned idle_cycles = 0;
  logic [7:0]  str_buf[$];

  function automatic void put_char(logic [7:0] c);
    // a single word never yields more than the block's result limit
    if (word_chars.size() < MaxResults) word_chars.push_back(c);
  endfunction

  function automatic void drop_held();
    held_q[0] = 8'h00;
    held_q[1] = 8'h00;
    held_q[2] = 8'h00;
    held_n = 2'd0;
    seq_n = 3'd0;
  endfunction

  // a byte met with nothing held
  function automatic void start_fresh(logic [7:0] b);
    if (b < 8'h20) begin
      put_char(ChBslash);
      case (b)
        8'h08: put_char(ChLowerB);
        8'h0C: put_char(ChLowerF);
        8'h0A: put_char(ChLowerN);
        8'h0D: put_char(ChLowerR);
        8'h09: put_char(ChLowerT);
        default: begin
          // \u00XX, upper-case hex
          put_char(ChLowerU);
          put_char(ChZero);
          put_char(ChZero);
          put_char(8'(hex_text[b[7:4]]));
          put_char(8'(hex_text[b[3:0]]));
        end
      endcase
    end else if (b < 8'h80) begin
      if (b == ChBslash || b == ChQuote) put_char(ChBslash);
      put_char(b);
    end else if (b >= 8'hC2 && b <= 8'hF4) begin
      // legal lead byte: wait for its continuation bytes
      held_q[0] = b;
      held_n = 2'd1;
      seq_n = (b < 8'hE0) ? 3'd2 : ((b < 8'hF0) ? 3'd3 : 3'd4);
    end else begin
      // stray continuation, overlong lead or lead beyond 10FFFF
      put_char(ChUnder);
    end
  endfunction

  function automatic void continue_seq(logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = 8'h80;
    hi = 8'hBF;
    if (held_n == 2'd0) begin
      drop_held();
      start_fresh(b);
      return;
    end
    // second byte ranges that rule out overlongs, surrogates and > 10FFFF
    if (held_n == 2'd1) begin
      case (held_q[0])
        8'hE0: lo = 8'hA0;
        8'hED: hi = 8'h9F;
        8'hF0: lo = 8'h90;
        8'hF4: hi = 8'h8F;
        default: ;
      endcase
    end
    if (b >= lo && b <= hi) begin
      if (int'(held_n) + 1 >= int'(seq_n)) begin
        for (int i = 0; i < int'(held_n); i++) put_char(held_q[i]);
        put_char(b);
        drop_held();
      end else begin
        held_q[held_n] = b;
        held_n = held_n + 2'd1;
      end
    end else begin
      // broken sequence: one underscore per held byte, then retry this byte
      for (int i = 0; i < int'(held_n); i++) put_char(ChUnder);
      drop_held();
      start_fresh(b);
    end
  endfunction

  // expected text for one accepted word, queued in order
  function automatic void escape_word(action_e act, logic [7:0] b, logic f, logic l);
    word_chars.delete();
    case (act)
      ActEmpty: begin
        drop_held();
        put_char(ChQuote);
        put_char(ChQuote);
      end
      ActNull: begin
        drop_held();
        put_char(ChLowerN);
        put_char(ChLowerU);
        put_char(ChLowerL);
        put_char(ChLowerL);
      end
      ActData: begin
        if (f) begin
          drop_held();
          put_char(ChQuote);
        end
        continue_seq(b);
        if (l) begin
          // truncated sequence at the end of the string
          for (int i = 0; i < int'(held_n); i++) put_char(ChUnder);
          drop_held();
          put_char(ChQuote);
        end
      end
      default: ;
    endcase
    foreach (word_chars[i])
      escaped_text_q.push_back(text_byte_t'{ch: word_chars[i],
                                             tail: (i == word_chars.size() - 1)});
  endfunction

  task automatic log_error(string msg);
    err_count++;
    if (err_count <= ShownErrors) $display("mismatch: %s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // output side: random back-pressure and the character checker
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 5'd1;
      out_ready <= (stall_left == 5'd1);
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left <= 5'($urandom_range(1, 19));
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    text_byte_t want;
    if (rst_ni && out_valid && out_ready) begin
      chars_checked++;
      if (escaped_text_q.size() == 0) begin
        log_error($sformatf("unexpected char 0x%02h run_end %0b", out_char, out_run_end));
      end else begin
        want = escaped_text_q.pop_front();
        if (out_char !== want.ch)
          log_error($sformatf("out_char expected 0x%02h got 0x%02h", want.ch, out_char));
        if (out_run_end !== want.tail)
          log_error($sformatf("run_end expected %0b got %0b (char 0x%02h)",
                              want.tail, out_run_end, want.ch));
      end
    end
  end

  // watchdog: too long with no word moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogMax) begin
        $display("timeout: no handshake for %0d cycles, %0d chars outstanding",
                 idle_cycles, escaped_text_q.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // present one word and hold it until accepted; valid stays high afterwards
  // so a following word can go out back to back
  task automatic send_word(action_e act, logic [7:0] b, logic f, logic l);
    if (send_pct != 0 && $urandom_range(0, 99) < send_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_byte <= b;
    in_first <= f;
    in_last <= l;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    escape_word(act, b, f, l);
    if (act != ActNone) data_words++;
  endtask

  task automatic send_bytes(logic [7:0] bytes[$], bit open_str, bit close_str);
    foreach (bytes[i])
      send_word(ActData, bytes[i], open_str && i == 0,
                close_str && i == bytes.size() - 1);
    strings_sent++;
  endtask

  // stop sending and let every expected character come out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (escaped_text_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'($urandom_range(8'h80, 8'hBF));
  endfunction

  // append one random token of string content to str_buf
  function automatic void add_token(int unsigned pick);
    logic [7:0] lead;
    if (pick < 40) begin
      str_buf.push_back(8'($urandom_range(8'h20, 8'h7E)));
    end else if (pick < 50) begin
      case ($urandom_range(0, 3))
        0: str_buf.push_back(ChBslash);
        1: str_buf.push_back(ChQuote);
        2: str_buf.push_back(8'h7F);
        default: str_buf.push_back(8'($urandom_range(8'h00, 8'h1F)));
      endcase
    end else if (pick < 60) begin
      str_buf.push_back(8'($urandom_range(8'hC2, 8'hDF)));
      str_buf.push_back(cont_byte());
    end else if (pick < 70) begin
      lead = 8'($urandom_range(8'hE0, 8'hEF));
      str_buf.push_back(lead);
      if (lead == 8'hE0) str_buf.push_back(8'($urandom_range(8'hA0, 8'hBF)));
      else if (lead == 8'hED) str_buf.push_back(8'($urandom_range(8'h80, 8'h9F)));
      else str_buf.push_back(cont_byte());
      str_buf.push_back(cont_byte());
    end else if (pick < 80) begin
      lead = 8'($urandom_range(8'hF0, 8'hF4));
      str_buf.push_back(lead);
      if (lead == 8'hF0) str_buf.push_back(8'($urandom_range(8'h90, 8'hBF)));
      else if (lead == 8'hF4) str_buf.push_back(8'($urandom_range(8'h80, 8'h8F)));
      else str_buf.push_back(cont_byte());
      str_buf.push_back(cont_byte());
      str_buf.push_back(cont_byte());
    end else if (pick < 90) begin
      // broken sequences of every kind
      case ($urandom_range(0, 6))
        0: str_buf.push_back(cont_byte());
        1: str_buf.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'hC0, 8'hC1))
                                                  : 8'($urandom_range(8'hF5, 8'hFF)));
        2: begin
          str_buf.push_back(8'($urandom_range(8'hC2, 8'hDF)));
          str_buf.push_back(8'($urandom_range(8'h00, 8'h7F)));
        end
        3: begin
          if ($urandom_range(0, 1)) begin
            str_buf.push_back(8'hE0);
            str_buf.push_back(8'($urandom_range(8'h80, 8'h9F)));
          end else begin
            str_buf.push_back(8'hF0);
            str_buf.push_back(8'($urandom_range(8'h80, 8'h8F)));
          end
          str_buf.push_back(cont_byte());
        end
        4: begin
          str_buf.push_back(8'hED);
          str_buf.push_back(8'($urandom_range(8'hA0, 8'hBF)));
          str_buf.push_back(cont_byte());
        end
        5: begin
          str_buf.push_back(8'hF4);
          str_buf.push_back(8'($urandom_range(8'h90, 8'hBF)));
          str_buf.push_back(cont_byte());
        end
        default: begin
          // lead with too few continuation bytes, then a random byte
          str_buf.push_back(8'($urandom_range(8'hE1, 8'hF3)));
          str_buf.push_back(8'hA5);
          str_buf.push_back(8'($urandom_range(8'h00, 8'hFF)));
        end
      endcase
    end else begin
      str_buf.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // short escapes, \u00XX, nul, backslash, quote, top ascii; bytes after the
  // first one continue the string without first_byte
  task automatic test_control_escapes();
    logic [7:0] s[$];
    s = {8'h00, 8'h08, 8'h0C, 8'h0A, 8'h0D, 8'h09, 8'h1F, ChBslash, ChQuote, 8'h7F};
    send_bytes(s, 1'b1, 1'b1);
  endtask

  // largest code point, overlong lead, surrogate, stray byte, broken sequence,
  // then a sequence cut off by the end of the string
  task automatic test_utf8_checks();
    logic [7:0] s[$];
    s = {8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'hC0, 8'hED, 8'hA0, 8'hFF, 8'hC3, 8'h41};
    send_bytes(s, 1'b1, 1'b1);
    s = {8'hE2, 8'h82};
    send_bytes(s, 1'b1, 1'b1);
  endtask

  // empty and null strings, the unused action, and a new string while a lead is held
  task automatic test_string_actions();
    send_word(ActEmpty, 8'hFF, 1'b1, 1'b1);
    send_word(ActNull, 8'h00, 1'b0, 1'b0);
    send_word(ActNone, 8'hA5, 1'b1, 1'b1);
    send_word(ActData, 8'hC2, 1'b1, 1'b0);
    send_word(ActData, 8'h41, 1'b1, 1'b1);
  endtask

  // sender holds off until all text is out, then resumes
  task automatic test_drain_pause();
    logic [7:0] s[$];
    s = {8'h01, 8'h1F, ChQuote};
    send_bytes(s, 1'b1, 1'b1);
    drain_results();
    s = {8'hE0, 8'hA0, 8'h80};
    send_bytes(s, 1'b1, 1'b1);
  endtask

  // mostly well-formed strings with random content, some noise words
  task automatic test_random_strings();
    int unsigned n_tok;
    while (data_words < TargetWords) begin
      if (data_words >= CalmAfter) begin
        send_pct = 0;
        stall_pct = 0;
      end else if ($urandom_range(0, 7) == 0) begin
        // some stretches run with no idling at all
        send_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 15);
      end
      if ($urandom_range(0, 99) < 15) begin
        send_word(action_e'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        str_buf.delete();
        n_tok = $urandom_range(1, 6);
        repeat (n_tok) add_token($urandom_range(0, 99));
        // now and then a string stays open or continues the previous one
        send_bytes(str_buf, $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0);
      end
      if (data_words < CalmAfter && $urandom_range(0, 49) == 0) drain_results();
    end
  endtask

  initial begin
    drop_held();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_control_escapes();
    test_utf8_checks();
    test_string_actions();
    test_drain_pause();
    test_random_strings();

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (escaped_text_q.size() != 0)
      log_error($sformatf("%0d expected chars never came", escaped_text_q.size()));

    $display("run covered %0d words in %0d strings, %0d json chars checked, %0d errors",
             data_words, strings_sent, chars_checked, err_count);
    $display("stimulus: escapes, valid and broken utf-8, empty/null strings, idle bursts");
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
